// ----- src/slis_pkg.sv -----
// shared types and codes for the sorted leaf insert and split block
package slis_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_SPLIT = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam int VALUE_BYTES = 32;
  localparam int LAST_BYTE   = 31;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [63:0] value_w0;
    logic [63:0] value_w1;
    logic [63:0] value_w2;
    logic [63:0] value_w3;
    logic [31:0] new_page;
    logic [3:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cell_key;
    logic [63:0] out_w0;
    logic [63:0] out_w1;
    logic [63:0] out_w2;
    logic [63:0] out_w3;
    logic [31:0] separator_key;
    logic [31:0] right_next;
    logic [4:0]  cell_count;
    logic        last;
  } out_item_t;

  // byte-wise value clean: zero after the first zero byte, and the final byte
  function automatic logic [255:0] clean_value(input logic [255:0] src);
    logic [255:0] dst;
    logic         ended;
    dst   = '0;
    ended = 1'b0;
    for (int b = 0; b < VALUE_BYTES; b++) begin
      if (b == LAST_BYTE) ended = 1'b1;
      if (!ended && src[8*b +: 8] == 8'd0) ended = 1'b1;
      if (!ended) dst[8*b +: 8] = src[8*b +: 8];
    end
    return dst;
  endfunction

endpackage

// ----- src/slis_cmp.sv -----
// shared key compare unit used by the search step
module slis_cmp import slis_pkg::*; (
  input  logic [31:0] probe_key,
  input  logic [31:0] item_key,
  output logic        equal,
  output logic        less
);
  // one unsigned compare per cycle
  assign equal = (probe_key == item_key);
  assign less  = (probe_key < item_key);
endmodule

// ----- src/sorted_leaf_insert_split_top.sv -----
// top level: leaf store, search and shift sequencer, split streaming
// One command is taken when start is high and busy is low. A read registers
// its result in the read state. An insert runs a binary search through one
// shared key comparator, then moves later cells up one slot a cycle and gives
// one done result; when the leaf is full the merged run is built one cell a
// cycle and the right half is streamed one result a cycle with last on the
// final one. Results carry a one-cycle strobe, valid, and cannot be held off
// by the receiver.
module sorted_leaf_insert_split_top import slis_pkg::*; #(
  parameter int MAX_CELLS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  cmd,
  output logic      busy,
  output logic      valid,
  output out_item_t result
);
  localparam int IW = $clog2(MAX_CELLS + 1);
  localparam int AW = $clog2(MAX_CELLS);
  localparam logic [IW-1:0] FULL = IW'(MAX_CELLS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;

  logic [2:0]    state;
  logic [IW-1:0] held_count;
  logic [31:0]   sibling_page;
  logic [31:0]   key_store [MAX_CELLS];
  logic [255:0]  value_store [MAX_CELLS];

  in_item_t      item;
  logic [255:0]  clean;
  logic [IW-1:0] lo, hi, idx, left, total;
  logic [31:0]   sep;

  // the cell spilled past the top during a split shift
  logic [31:0]   spill_key;
  logic [255:0]  spill_val;

  logic [IW-1:0] mid;
  logic          c_eq, c_lt;

  assign mid = lo + ((hi - lo) >> 1);

  slis_cmp u_cmp (
    .probe_key (key_store[mid[AW-1:0]]),
    .item_key  (item.key),
    .equal     (c_eq),
    .less      (c_lt)
  );

  assign busy = (state != S_IDLE);

  // cell at merged position p of the n+1 run (after shifting, store holds
  // the run's first n entries and spill holds entry n)
  logic [31:0]  run_key;
  logic [255:0] run_val;
  always_comb begin
    if (idx == FULL) begin
      run_key = spill_key;
      run_val = spill_val;
    end else begin
      run_key = key_store[idx[AW-1:0]];
      run_val = value_store[idx[AW-1:0]];
    end
  end

  // read answer for the held slot
  out_item_t read_res;
  always_comb begin
    read_res            = '0;
    read_res.kind       = KIND_EMPTY;
    read_res.cell_count = 5'(held_count);
    read_res.last       = 1'b1;
    if (32'(item.slot) < 32'(held_count) && 32'(item.slot) < 32'(MAX_CELLS)) begin
      read_res.kind     = KIND_DATA;
      read_res.cell_key = key_store[AW'(item.slot)];
      {read_res.out_w3, read_res.out_w2, read_res.out_w1, read_res.out_w0} =
        value_store[AW'(item.slot)];
    end
  end

  // done answer for an insert that fits
  out_item_t done_res;
  always_comb begin
    done_res            = '0;
    done_res.kind       = KIND_DONE;
    done_res.cell_key   = item.key;
    {done_res.out_w3, done_res.out_w2, done_res.out_w1, done_res.out_w0} = clean;
    done_res.cell_count = 5'(held_count + 1'b1);
    done_res.last       = 1'b1;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= (state == S_READ) || (state == S_EMIT) ||
               (state == S_SHIFT && idx <= lo && held_count < FULL);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held_count   <= '0;
      sibling_page <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item  <= cmd;
            clean <= clean_value({cmd.value_w3, cmd.value_w2,
                                  cmd.value_w1, cmd.value_w0});
            lo    <= '0;
            hi    <= held_count;
            state <= (cmd.op == OP_READ) ? S_READ : S_SEARCH;
          end
        end
        S_READ: begin
          result <= read_res;
          state  <= S_IDLE;
        end
        S_SEARCH: begin
          if (lo >= hi || c_eq) begin
            if (lo < hi) lo <= mid;
            idx   <= held_count;
            state <= S_SHIFT;
          end else if (c_lt) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
        end
        S_SHIFT: begin
          // idx walks down from n to pos, one cell a cycle
          if (idx > lo) begin
            if (idx == FULL) begin
              spill_key <= key_store[AW'(idx - 1'b1)];
              spill_val <= value_store[AW'(idx - 1'b1)];
            end else begin
              key_store[idx[AW-1:0]]   <= key_store[AW'(idx - 1'b1)];
              value_store[idx[AW-1:0]] <= value_store[AW'(idx - 1'b1)];
            end
            idx <= idx - 1'b1;
          end else begin
            if (lo == FULL) begin
              spill_key <= item.key;
              spill_val <= clean;
            end else begin
              key_store[lo[AW-1:0]]   <= item.key;
              value_store[lo[AW-1:0]] <= clean;
            end
            if (held_count < FULL) begin
              held_count <= held_count + 1'b1;
              result     <= done_res;
              state      <= S_IDLE;
            end else begin
              total <= FULL;
              left  <= IW'((MAX_CELLS + 1) / 2);
              idx   <= IW'((MAX_CELLS + 1) / 2);
              state <= S_MOVE;
            end
          end
        end
        S_MOVE: begin
          // latch separator, then stream
          sep        <= run_key;
          held_count <= left;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          result.kind          <= KIND_SPLIT;
          result.cell_key      <= run_key;
          {result.out_w3, result.out_w2, result.out_w1, result.out_w0} <= run_val;
          result.separator_key <= sep;
          result.right_next    <= sibling_page;
          result.cell_count    <= 5'(total + 1'b1 - left);
          result.last          <= (idx == total);
          if (idx == total) begin
            sibling_page <= item.new_page;
            state        <= S_IDLE;
          end
          idx <= idx + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the leaf never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    held_count <= FULL) else $error("held count above capacity");
  // a result strobe only ever comes in the cycle after busy work
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy)) else $error("result without work");
  // a new command is never taken while a split is streaming
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> busy) else $error("emit while idle");
  // a done result grows the leaf by one
  a_done_grow: assert property (@(posedge clk) disable iff (rst)
    (valid && result.kind == KIND_DONE) |-> 32'(result.cell_count) == 32'(held_count))
    else $error("done count mismatch");
endmodule
